// ===== rtl/msmp_pkg.sv =====
// ----------------------------------------------------------------------------
// msmp_pkg
// shared widths, codes and reset values of the midi message parser
// ----------------------------------------------------------------------------
package msmp_pkg;

	// configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_FILTER = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_SILENCE_TIMEOUT = 1'b1;

	// field widths
	localparam int CHAN_W    = 5;
	localparam int DATA7_W   = 7;
	localparam int KIND_W    = 2;
	localparam int TIMEOUT_W = 16;
	localparam int SILENCE_W = 17;
	localparam int OUT_TDATA_W = 24;

	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd300;
	localparam logic [SILENCE_W-1:0] SILENCE_MAX   = '1;

	// result kinds
	localparam logic [KIND_W-1:0] EV_NOTE_ON  = 2'd0;
	localparam logic [KIND_W-1:0] EV_NOTE_OFF = 2'd1;
	localparam logic [KIND_W-1:0] EV_CTRL     = 2'd2;
	localparam logic [KIND_W-1:0] EV_LOST     = 2'd3;

	// input kinds
	localparam logic MODE_BYTE = 1'b0;
	localparam logic MODE_TICK = 1'b1;

	// status byte high nibbles
	localparam logic [3:0] ST_NOTE_OFF  = 4'h8;
	localparam logic [3:0] ST_NOTE_ON   = 4'h9;
	localparam logic [3:0] ST_POLY_PRES = 4'hA;
	localparam logic [3:0] ST_CTRL      = 4'hB;
	localparam logic [3:0] ST_PROG      = 4'hC;
	localparam logic [3:0] ST_CHAN_PRES = 4'hD;
	localparam logic [3:0] ST_BEND      = 4'hE;
	localparam logic [3:0] ST_SYSTEM    = 4'hF;

	localparam logic [7:0] BYTE_REALTIME_MIN = 8'hF8;
	localparam logic [7:0] BYTE_ACTIVE_SENSE = 8'hFE;

endpackage

// ===== rtl/midi_stream_message_parser_unit.sv =====
// ----------------------------------------------------------------------------
// midi_stream_message_parser_unit
// running-status midi parser with channel filter and active-sensing watchdog
// ----------------------------------------------------------------------------
// path: a taken beat sits in the input register and its result is loaded into
//   the output register once the output slot is free
// throughput: one beat per cycle; s_axis_tready drops only while the input
//   register holds a beat and a full output register is stalled
// reset: arst_n clears parser state, watchdog and the valid flags at once;
//   channel filter returns to 0 (omni) and the silence timeout to 300 ms
module midi_stream_message_parser_unit (
	input  logic clk,
	input  logic arst_n,
	// configuration writes
	input  logic                               cfg_we,
	input  logic [msmp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [msmp_pkg::CFG_DATA_W-1:0]    cfg_data,
	// input beats
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] byte_value
	input  logic       s_axis_tuser,   // [0] mode
	// result beats
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [msmp_pkg::OUT_TDATA_W-1:0] m_axis_tdata,  // [4:0] channel,
	                                                        // [11:5] first_data,
	                                                        // [18:12] second_data,
	                                                        // [23:19] zero
	output logic [msmp_pkg::KIND_W-1:0]      m_axis_tuser   // [1:0] event_kind
);

	// configuration registers
	logic [msmp_pkg::CHAN_W-1:0]    chan_filter_q;
	logic [msmp_pkg::TIMEOUT_W-1:0] timeout_q;

	// input register
	logic       valid_s1;
	logic       mode_s1;
	logic [7:0] byte_s1;

	// parser and watchdog state
	logic [7:0]                     run_status_q;
	logic [1:0]                     data_cnt_q;
	logic [1:0]                     exp_cnt_q;
	logic [msmp_pkg::DATA7_W-1:0]   held_d1_q;
	logic                           armed_q;
	logic                           lost_q;
	logic [msmp_pkg::SILENCE_W-1:0] silence_q;

	// output register
	logic                           out_valid_q;
	logic [msmp_pkg::KIND_W-1:0]    out_kind_q;
	logic [msmp_pkg::CHAN_W-1:0]    out_chan_q;
	logic [msmp_pkg::DATA7_W-1:0]   out_d1_q;
	logic [msmp_pkg::DATA7_W-1:0]   out_d2_q;

	// next-state values from the beat held in the input register
	logic [7:0]                     run_status_d;
	logic [1:0]                     data_cnt_d;
	logic [1:0]                     exp_cnt_d;
	logic [msmp_pkg::DATA7_W-1:0]   held_d1_d;
	logic                           armed_d;
	logic                           lost_d;
	logic [msmp_pkg::SILENCE_W-1:0] silence_d;
	logic                           res_valid;
	logic [msmp_pkg::KIND_W-1:0]    res_kind;
	logic [msmp_pkg::CHAN_W-1:0]    res_chan;
	logic [msmp_pkg::DATA7_W-1:0]   res_d1;
	logic [msmp_pkg::DATA7_W-1:0]   res_d2;

	logic [1:0]                     cnt_inc;
	logic [msmp_pkg::DATA7_W-1:0]   msg_d1;
	logic [msmp_pkg::DATA7_W-1:0]   msg_d2;
	logic [msmp_pkg::CHAN_W-1:0]    msg_chan;
	logic                           chan_ok;

	logic out_free;
	logic advance;

	// the output slot is free when empty or being drained this cycle
	assign out_free      = !out_valid_q || m_axis_tready;
	assign advance       = valid_s1 && out_free;
	assign s_axis_tready = !valid_s1 || out_free;

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_kind_q;
	assign m_axis_tdata  = {5'd0, out_d2_q, out_d1_q, out_chan_q};

	// message fields as they look if this data byte completes a message
	assign cnt_inc  = data_cnt_q + 2'd1;
	assign msg_d1   = (data_cnt_q == 2'd0) ? byte_s1[6:0] : held_d1_q;
	assign msg_d2   = (exp_cnt_q > 2'd1) ? byte_s1[6:0] : '0;
	assign msg_chan = {1'b0, run_status_q[3:0]} + 5'd1;
	assign chan_ok  = (chan_filter_q == '0) || (chan_filter_q == msg_chan);

	always_comb begin
		run_status_d = run_status_q;
		data_cnt_d   = data_cnt_q;
		exp_cnt_d    = exp_cnt_q;
		held_d1_d    = held_d1_q;
		armed_d      = armed_q;
		lost_d       = lost_q;
		silence_d    = silence_q;
		res_valid    = 1'b0;
		res_kind     = msmp_pkg::EV_LOST;
		res_chan     = 5'd1;
		res_d1       = '0;
		res_d2       = '0;

		if (mode_s1 == msmp_pkg::MODE_TICK) begin
			// saturating millisecond count, one lost event per silence
			if (silence_q != msmp_pkg::SILENCE_MAX) begin
				silence_d = silence_q + 17'd1;
			end
			if (armed_q && !lost_q && (silence_d > {1'b0, timeout_q})) begin
				lost_d    = 1'b1;
				res_valid = 1'b1;
			end
		end else begin
			// any byte counts as traffic
			silence_d = '0;
			lost_d    = 1'b0;
			if (byte_s1 >= msmp_pkg::BYTE_REALTIME_MIN) begin
				// real-time: only active sensing leaves a trace
				if (byte_s1 == msmp_pkg::BYTE_ACTIVE_SENSE) begin
					armed_d = 1'b1;
				end
			end else if (byte_s1[7:4] == msmp_pkg::ST_SYSTEM) begin
				// system common cancels running status
				run_status_d = '0;
				data_cnt_d   = '0;
			end else if (byte_s1[7]) begin
				run_status_d = byte_s1;
				data_cnt_d   = '0;
				case (byte_s1[7:4]) inside
					msmp_pkg::ST_PROG, msmp_pkg::ST_CHAN_PRES: exp_cnt_d = 2'd1;
					default:                                   exp_cnt_d = 2'd2;
				endcase
			end else if (run_status_q != '0) begin
				if (data_cnt_q == 2'd0) begin
					held_d1_d = byte_s1[6:0];
				end
				if (cnt_inc < exp_cnt_q) begin
					data_cnt_d = cnt_inc;
				end else begin
					data_cnt_d = '0;
					res_chan   = msg_chan;
					res_d1     = msg_d1;
					unique case (run_status_q[7:4])
						msmp_pkg::ST_NOTE_ON: begin
							res_valid = chan_ok;
							if (msg_d2 != '0) begin
								res_kind = msmp_pkg::EV_NOTE_ON;
								res_d2   = msg_d2;
							end else begin
								res_kind = msmp_pkg::EV_NOTE_OFF;
							end
						end
						msmp_pkg::ST_NOTE_OFF: begin
							res_valid = chan_ok;
							res_kind  = msmp_pkg::EV_NOTE_OFF;
						end
						msmp_pkg::ST_CTRL: begin
							res_valid = chan_ok;
							res_kind  = msmp_pkg::EV_CTRL;
							res_d2    = msg_d2;
						end
						// pressure, program change and bend are dropped
						default: res_valid = 1'b0;
					endcase
				end
			end
		end
	end

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_filter_q <= '0;
			timeout_q     <= msmp_pkg::TIMEOUT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				msmp_pkg::REG_CHANNEL_FILTER:  chan_filter_q <= cfg_data[msmp_pkg::CHAN_W-1:0];
				msmp_pkg::REG_SILENCE_TIMEOUT: timeout_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			mode_s1 <= s_axis_tuser;
			byte_s1 <= s_axis_tdata;
		end
	end

	// parser state advances once per beat leaving the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_status_q <= '0;
			data_cnt_q   <= '0;
			exp_cnt_q    <= '0;
			held_d1_q    <= '0;
			armed_q      <= 1'b0;
			lost_q       <= 1'b0;
			silence_q    <= '0;
		end else if (advance) begin
			run_status_q <= run_status_d;
			data_cnt_q   <= data_cnt_d;
			exp_cnt_q    <= exp_cnt_d;
			held_d1_q    <= held_d1_d;
			armed_q      <= armed_d;
			lost_q       <= lost_d;
			silence_q    <= silence_d;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			out_kind_q <= res_kind;
			out_chan_q <= res_chan;
			out_d1_q   <= res_d1;
			out_d2_q   <= res_d2;
		end
	end

endmodule

// ===== rtl/msmp_checker.sv =====
// ----------------------------------------------------------------------------
// msmp_checker
// port-level checks on the result stream of the midi message parser
// ----------------------------------------------------------------------------
module msmp_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             m_axis_tvalid,
	input logic                             m_axis_tready,
	input logic [msmp_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	input logic [msmp_pkg::KIND_W-1:0]      m_axis_tuser
);

	// stalled result beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result beat changed while stalled");

	// transport lost carries channel 1 and no data
	a_lost: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == msmp_pkg::EV_LOST) |->
		(m_axis_tdata == 24'd1))
		else $error("transport lost beat with payload");

	// note off never carries velocity
	a_off: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == msmp_pkg::EV_NOTE_OFF) |->
		(m_axis_tdata[18:12] == 7'd0))
		else $error("note off with velocity");

	// channel in 1..16 and padding zero
	a_chan: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |->
		(m_axis_tdata[4:0] != 5'd0) && (m_axis_tdata[4:0] <= 5'd16) &&
		(m_axis_tdata[23:19] == 5'd0))
		else $error("bad channel or padding");

endmodule

bind midi_stream_message_parser_unit msmp_checker u_msmp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);
